// ----- hdl/lbe_pkg.sv -----
// Lagrange basis evaluator: shared widths, codes, types and small tables.
// No dependencies.
package lbe_pkg;

    localparam int DEG_W      = 3;
    localparam int IDX_W      = 3;
    localparam int ORD_W      = 2;
    localparam int POS_W      = 16;
    localparam int VAL_W      = 32;
    localparam int DEG_LIMIT  = 6;
    localparam int X_OFFSET   = 16384;
    localparam int HALF_BITS  = 15;
    localparam int T_W        = 20;
    localparam int ACC_W      = 120;
    localparam int LIMB_W     = 30;
    localparam int LIMBS      = 4;
    localparam int PP_W       = LIMB_W + 1 + T_W;
    localparam int PD_W       = 6;
    localparam int MPP_W      = LIMB_W + PD_W;
    localparam int MAG_W      = 128;
    localparam int DEN_W      = 10;
    localparam int S_W        = 7;
    localparam int Q_W        = 32;
    localparam int Y_W        = 41;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = Q_W / DIV_STEPS;

    localparam logic [ORD_W-1:0] ORD_VALUE  = 2'd0;
    localparam logic [ORD_W-1:0] ORD_FIRST  = 2'd1;
    localparam logic [ORD_W-1:0] ORD_SECOND = 2'd2;
    localparam logic [ORD_W-1:0] ORD_BAD    = 2'd3;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic                   vld;
        logic                   bad;
        logic [DEG_W-1:0]       p;
        logic [IDX_W-1:0]       k;
        logic [ORD_W-1:0]       d;
        logic signed [T_W-1:0]  t;
    } t_ctrl;

    typedef logic [2:0][ACC_W-1:0] t_jet;

    typedef struct packed {
        logic             vld;
        logic             bad;
        logic             neg;
        logic             sat;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   num;
    } t_div;

    // |prod_{j!=k, j<=p} (k-j)|
    function automatic logic [DEN_W-1:0] den_mag(logic [DEG_W-1:0] p, logic [IDX_W-1:0] k);
        logic [DEN_W-1:0] acc;
        logic [IDX_W-1:0] diff;
        acc = DEN_W'(1);
        for (int j = 0; j <= DEG_LIMIT; j++) begin
            if (IDX_W'(j) != k && DEG_W'(j) <= p) begin
                diff = (IDX_W'(j) > k) ? IDX_W'(j) - k : k - IDX_W'(j);
                acc  = DEN_W'(acc * diff);
            end
        end
        return acc;
    endfunction

    function automatic logic [PD_W-1:0] deriv_scale(logic [DEG_W-1:0] p, logic [ORD_W-1:0] d);
        logic [PD_W-1:0] pw;
        pw = PD_W'(p);
        unique case (d)
            ORD_FIRST:  return pw;
            ORD_SECOND: return PD_W'(pw * pw);
            default:    return PD_W'(1);
        endcase
    endfunction

endpackage

// ----- hdl/lbe_if.sv -----
// Lagrange basis evaluator: valid/ready channel interfaces for input and result words.
// Depends on lbe_pkg.
interface lbe_in_if import lbe_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        basis_index;
    logic [ORD_W-1:0]        derivative_order;
    logic signed [POS_W-1:0] position;

    modport source (output valid, output basis_index, output derivative_order,
                    output position, input ready);
    modport sink   (input valid, input basis_index, input derivative_order,
                    input position, output ready);
endinterface

interface lbe_out_if import lbe_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] basis_value;
    logic                    bad_select;

    modport source (output valid, output basis_value, output bad_select, input ready);
    modport sink   (input valid, input basis_value, input bad_select, output ready);
endinterface

// ----- hdl/lbe_cell.sv -----
// Lagrange basis evaluator: one node cell, multiplies the value/derivative jet by (t - node).
// Two register stages: limb products, then recombine. Depends on lbe_pkg.
module lbe_cell import lbe_pkg::*; #(
    parameter int NODE = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_ctrl i_ctrl,
    input  t_jet  i_jet,
    output t_ctrl o_ctrl,
    output t_jet  o_jet
);

    localparam logic signed [T_W:0] NODE_OFF = (T_W+1)'(NODE * (2 ** HALF_BITS));

    logic                    w_act;
    logic signed [T_W:0]     w_fw;
    logic signed [T_W-1:0]   w_f;
    logic signed [LIMB_W:0]  w_lv;
    logic signed [PP_W-1:0]  n_pp [3][LIMBS];

    t_ctrl                   r_a_ctrl;
    logic                    r_a_act;
    t_jet                    r_a_jet;
    logic signed [PP_W-1:0]  r_pp [3][LIMBS];

    t_ctrl                   r_b_ctrl;
    t_jet                    r_b_jet;
    t_jet                    n_b_jet;
    logic [ACC_W-1:0]        w_acc;

    assign w_act = (i_ctrl.k != IDX_W'(NODE)) && (DEG_W'(NODE) <= i_ctrl.p);
    assign w_fw  = {i_ctrl.t[T_W-1], i_ctrl.t} - NODE_OFF;
    assign w_f   = w_fw[T_W-1:0];

    always_comb begin
        w_lv = '0;
        for (int c = 0; c < 3; c++) begin
            for (int l = 0; l < LIMBS; l++) begin
                if (l == LIMBS - 1) begin
                    w_lv = {i_jet[c][ACC_W-1], i_jet[c][l*LIMB_W +: LIMB_W]};
                end else begin
                    w_lv = {1'b0, i_jet[c][l*LIMB_W +: LIMB_W]};
                end
                n_pp[c][l] = w_lv * w_f;
            end
        end
    end

    always_comb begin
        w_acc = '0;
        for (int c = 0; c < 3; c++) begin
            w_acc = '0;
            for (int l = 0; l < LIMBS; l++) begin
                w_acc = w_acc + (ACC_W'(r_pp[c][l]) << (LIMB_W * l));
            end
            if (c > 0) begin
                w_acc = w_acc + (r_a_jet[c-1] << HALF_BITS);
            end
            n_b_jet[c] = r_a_act ? w_acc : r_a_jet[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctrl.vld <= 1'b0;
            r_b_ctrl.vld <= 1'b0;
        end else if (i_en) begin
            r_a_ctrl <= i_ctrl;
            r_b_ctrl <= r_a_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_act <= w_act;
            r_a_jet <= i_jet;
            r_pp    <= n_pp;
            r_b_jet <= n_b_jet;
        end
    end

    assign o_ctrl = r_b_ctrl;
    assign o_jet  = r_b_jet;

endmodule

// ----- hdl/lbe_div_step.sv -----
// Lagrange basis evaluator: one restoring divider stage, DIV_STEPS (4) quotient bits each.
// Depends on lbe_pkg.
module lbe_div_step import lbe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_div,
    output t_div o_div
);

    t_div             r_div;
    t_div             n_div;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        n_div   = i_div;
        w_trial = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            w_trial   = {n_div.rem, n_div.num[Q_W-1]};
            n_div.num = {n_div.num[Q_W-2:0], 1'b0};
            if (w_trial >= {1'b0, n_div.den}) begin
                n_div.rem    = DEN_W'(w_trial - {1'b0, n_div.den});
                n_div.num[0] = 1'b1;
            end else begin
                n_div.rem = w_trial[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.vld <= 1'b0;
        end else if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

// ----- hdl/lagrange_basis_evaluator.sv -----
// Equispaced Lagrange basis evaluator on [-1,1]: value, first or second derivative per word.
// Top level; depends on lbe_pkg, lbe_if, lbe_cell and lbe_div_step.
//
// Takes one input word per clock while i_in.ready is high and returns one result word per
// input word, in order. Pipeline: one input register, two registers in each of
// the MAX_DEGREE+1 node cells (one per node of the finest grid, each multiplying the running
// value/derivative products by its node factor), four scaling and rounding stages, eight
// divider stages of four quotient bits each, and the output register. The chain stalls as a
// whole only when both the output register and the skid register hold words. Results are
// exact, rounded half away from zero and saturated to Q15.16; an index of 0 or beyond
// degree+1 or an order of 3 gives zero with bad_select. A degree of 0 acts as 1, one above
// MAX_DEGREE acts as MAX_DEGREE.
module lagrange_basis_evaluator import lbe_pkg::*; #(
    parameter int MAX_DEGREE = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DEG_W-1:0] i_cfg_data,
    lbe_in_if.sink           i_in,
    lbe_out_if.source        o_out
);

    localparam int CELLS = MAX_DEGREE + 1;

    logic [DEG_W-1:0]          r_cfg_degree;
    logic [DEG_W-1:0]          w_p;
    logic                      w_en;
    logic signed [POS_W:0]     w_xp;
    logic signed [POS_W+DEG_W+1:0] w_tp;
    t_ctrl                     n_pre;
    t_ctrl                     r_pre;

    t_ctrl                     w_ctrl [CELLS+1];
    t_jet                      w_jet  [CELLS+1];

    // post-chain stages
    logic [ACC_W-1:0]          w_sel;
    logic                      r1_vld, r1_bad, r1_neg;
    logic [ACC_W-1:0]          r1_mag;
    logic [PD_W-1:0]           r1_pd;
    logic [DEN_W-1:0]          r1_den;
    logic [S_W-1:0]            r1_s;

    logic                      r2_vld, r2_bad, r2_neg;
    logic [MPP_W-1:0]          r2_pp [LIMBS];
    logic [DEN_W-1:0]          r2_den;
    logic [S_W-1:0]            r2_s;

    logic                      r3_vld, r3_bad, r3_neg;
    logic [MAG_W-1:0]          r3_mp;
    logic [MAG_W-1:0]          w_mp;
    logic [DEN_W-1:0]          r3_den;
    logic [S_W-1:0]            r3_s;

    logic [MAG_W-1:0]          w_y;
    t_div                      n_div0;
    t_div                      r_div0;
    t_div                      w_div [DIV_STAGES+1];
    t_div                      w_fin;

    logic [VAL_W-1:0]          w_fin_val;
    logic                      w_push, w_pop;
    logic                      r_out_vld, r_out_bad;
    logic [VAL_W-1:0]          r_out_val;
    logic                      r_skid_vld, r_skid_bad;
    logic [VAL_W-1:0]          r_skid_val;

    assign w_en       = ~r_skid_vld;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_degree <= DEG_W'(1);
        end else if (i_cfg_we) begin
            r_cfg_degree <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_cfg_degree == '0) begin
            w_p = DEG_W'(1);
        end else if (r_cfg_degree > DEG_W'(MAX_DEGREE)) begin
            w_p = DEG_W'(MAX_DEGREE);
        end else begin
            w_p = r_cfg_degree;
        end
    end

    // t = p * (X + 1.0) / 2 scaled by 2^15, with X scaled by 2^14
    assign w_xp = {i_in.position[POS_W-1], i_in.position} + (POS_W+1)'(X_OFFSET);
    assign w_tp = w_xp * $signed({1'b0, w_p});

    always_comb begin
        n_pre.vld = i_in.valid;
        n_pre.bad = (i_in.basis_index == '0) ||
                    ({1'b0, i_in.basis_index} > ({1'b0, w_p} + (DEG_W+1)'(1))) ||
                    (i_in.derivative_order == ORD_BAD);
        n_pre.p   = w_p;
        n_pre.k   = i_in.basis_index - IDX_W'(1);
        n_pre.d   = i_in.derivative_order;
        n_pre.t   = w_tp[T_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.vld <= 1'b0;
        end else if (w_en) begin
            r_pre <= n_pre;
        end
    end

    assign w_ctrl[0]   = r_pre;
    assign w_jet[0][0] = ACC_W'(1);
    assign w_jet[0][1] = '0;
    assign w_jet[0][2] = '0;

    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        lbe_cell #(.NODE(j)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_ctrl (w_ctrl[j]),
            .i_jet  (w_jet[j]),
            .o_ctrl (w_ctrl[j+1]),
            .o_jet  (w_jet[j+1])
        );
    end

    // pick order, second order doubled; r1_neg folds in the denominator sign
    always_comb begin
        unique case (w_ctrl[CELLS].d)
            ORD_VALUE:  w_sel = w_jet[CELLS][0];
            ORD_FIRST:  w_sel = w_jet[CELLS][1];
            ORD_SECOND: w_sel = w_jet[CELLS][2] << 1;
            default:    w_sel = '0;
        endcase
    end

    always_comb begin
        w_mp = '0;
        for (int l = 0; l < LIMBS; l++) begin
            w_mp = w_mp + (MAG_W'(r2_pp[l]) << (LIMB_W * l));
        end
        w_mp = (w_mp << 2) + (MAG_W'(r2_den) << r2_s);
    end

    assign w_y = r3_mp >> (r3_s + S_W'(1));

    always_comb begin
        n_div0.vld = r3_vld;
        n_div0.bad = r3_bad;
        n_div0.neg = r3_neg;
        n_div0.sat = (w_y >> (Q_W - 1)) >= MAG_W'(r3_den);
        n_div0.den = r3_den;
        n_div0.rem = DEN_W'(w_y[Y_W-1:Q_W]);
        n_div0.num = w_y[Q_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld     <= 1'b0;
            r2_vld     <= 1'b0;
            r3_vld     <= 1'b0;
            r_div0.vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= w_ctrl[CELLS].vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r_div0 <= n_div0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_bad <= w_ctrl[CELLS].bad;
            r1_neg <= w_sel[ACC_W-1] ^ (w_ctrl[CELLS].p[0] ^ w_ctrl[CELLS].k[0]);
            r1_mag <= w_sel[ACC_W-1] ? -w_sel : w_sel;
            r1_pd  <= deriv_scale(w_ctrl[CELLS].p, w_ctrl[CELLS].d);
            r1_den <= den_mag(w_ctrl[CELLS].p, w_ctrl[CELLS].k);
            r1_s   <= S_W'(w_ctrl[CELLS].p) * S_W'(HALF_BITS) - S_W'(HALF_BITS)
                      + S_W'(w_ctrl[CELLS].d);

            r2_bad <= r1_bad;
            r2_neg <= r1_neg;
            for (int l = 0; l < LIMBS; l++) begin
                r2_pp[l] <= MPP_W'(r1_mag[l*LIMB_W +: LIMB_W]) * MPP_W'(r1_pd);
            end
            r2_den <= r1_den;
            r2_s   <= r1_s;

            r3_bad <= r2_bad;
            r3_neg <= r2_neg;
            r3_mp  <= w_mp;
            r3_den <= r2_den;
            r3_s   <= r2_s;
        end
    end

    assign w_div[0] = r_div0;

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        lbe_div_step u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_div  (w_div[i]),
            .o_div  (w_div[i+1])
        );
    end

    assign w_fin = w_div[DIV_STAGES];

    always_comb begin
        if (w_fin.bad) begin
            w_fin_val = '0;
        end else if (w_fin.sat) begin
            w_fin_val = w_fin.neg ? VAL_MIN : VAL_MAX;
        end else begin
            w_fin_val = w_fin.neg ? VAL_W'(-w_fin.num) : w_fin.num;
        end
    end

    assign w_push = w_en & w_fin.vld;
    assign w_pop  = r_out_vld & o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_vld && !w_pop) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_pop) begin
                r_out_val <= r_skid_val;
                r_out_bad <= r_skid_bad;
            end
        end else if (w_push) begin
            if (r_out_vld && !w_pop) begin
                r_skid_val <= w_fin_val;
                r_skid_bad <= w_fin.bad;
            end else begin
                r_out_val <= w_fin_val;
                r_out_bad <= w_fin.bad;
            end
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.basis_value = r_out_val;
    assign o_out.bad_select  = r_out_bad;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held with empty output register");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_bad) |-> (r_out_val == '0))
        else $error("bad selection with nonzero value");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin.vld && !w_fin.sat) |-> (w_fin.rem < w_fin.den))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ----- tb/lbe_tb_pkg_dummy.sv -----
`timescale 1ns / 100ps
// Testbench side helpers for the Lagrange basis evaluator: result word type.
// Depends on lbe_pkg.
package lbe_tb_types;
    import lbe_pkg::*;

    typedef struct {
        logic signed [VAL_W-1:0] basis_value;
        logic                    bad_select;
    } t_basis_word;
endpackage

// ----- tb/lagrange_basis_evaluator_tb.sv -----
`timescale 1ns / 100ps
// Testbench for lagrange_basis_evaluator: random and directed words with an exact predictor
// and an in-order scoreboard. Depends on lbe_pkg, lbe_if, lbe_tb_types and the block RTL.
module lagrange_basis_evaluator_tb;
    import lbe_pkg::*;
    import lbe_tb_types::*;

    localparam int LATENCY   = 2 * (DEG_LIMIT + 1) + 14;
    localparam int CYCLE_CAP = 400000;
    localparam int WIDE      = 192;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [DEG_W-1:0] i_cfg_data;

    lbe_in_if  in_ch ();
    lbe_out_if out_ch ();

    lagrange_basis_evaluator #(.MAX_DEGREE(DEG_LIMIT)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    int               mismatches = 0;
    int               cycles = 0;
    bit               quiet = 0;
    logic [DEG_W-1:0] degree_reg = 3'd1;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    class basis_scoreboard;
        t_basis_word pending[$];

        function void note(t_basis_word w);
            pending.push_back(w);
        endfunction

        task check(t_basis_word got);
            t_basis_word want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected word value=%h bad=%b",
                                          got.basis_value, got.bad_select));
            end else begin
                want = pending.pop_front();
                if (got.basis_value !== want.basis_value)
                    report_mismatch($sformatf("basis_value got %h want %h",
                                              got.basis_value, want.basis_value));
                if (got.bad_select !== want.bad_select)
                    report_mismatch($sformatf("bad_select got %b want %b",
                                              got.bad_select, want.bad_select));
            end
        endtask
    endclass

    basis_scoreboard board = new();

    // product over nodes j != k of (t - j*2^15), 2^15 for nodes in mask
    function automatic logic signed [WIDE-1:0] node_product(int k, int p, int t, int mask);
        logic signed [WIDE-1:0] r;
        logic signed [WIDE-1:0] f;
        r = 1;
        for (int j = 0; j <= p; j++) begin
            if (j != k) begin
                f = ((mask >> j) & 1) ? 32768 : (t - j * 32768);
                r = r * f;
            end
        end
        return r;
    endfunction

    function automatic t_basis_word predict_basis(logic [DEG_W-1:0] deg, logic [IDX_W-1:0] idx,
                                                  logic [ORD_W-1:0] ord,
                                                  logic signed [POS_W-1:0] pos);
        t_basis_word            w;
        logic signed [WIDE-1:0] sum, mag, r, dw, lim;
        int                     p, k, x, t, den, s;
        bit                     neg;
        p = deg;
        if (p < 1) p = 1;
        if (p > DEG_LIMIT) p = DEG_LIMIT;
        w.basis_value = '0;
        w.bad_select  = 1'b1;
        if (idx < 1 || idx > p + 1 || ord > ORD_SECOND) return w;
        w.bad_select = 1'b0;
        k = idx - 1;
        x = pos;
        t = p * (x + X_OFFSET);
        sum = 0;
        if (ord == ORD_VALUE) begin
            sum = node_product(k, p, t, 0);
        end else if (ord == ORD_FIRST) begin
            for (int m = 0; m <= p; m++)
                if (m != k) sum = sum + node_product(k, p, t, 1 << m);
        end else begin
            for (int m = 0; m <= p; m++)
                for (int n = 0; n <= p; n++)
                    if (m != k && n != k && m != n)
                        sum = sum + node_product(k, p, t, (1 << m) | (1 << n));
        end
        den = 1;
        for (int j = 0; j <= p; j++)
            if (j != k) den = den * (k - j);
        if (den < 0) begin
            sum = -sum;
            den = -den;
        end
        for (int i = 0; i < ord; i++) sum = sum * p;
        sum = sum * 2;
        s   = 15 * p - 15 + ord;
        neg = sum < 0;
        mag = neg ? -sum : sum;
        dw  = den;
        r   = ((mag <<< 1) + (dw <<< s)) / dw;
        r   = r >>> (s + 1);
        lim = 1;
        lim = lim <<< 31;
        if (neg) w.basis_value = (r >= lim) ? VAL_MIN : -r[VAL_W-1:0];
        else     w.basis_value = (r > lim - 1) ? VAL_MAX : r[VAL_W-1:0];
        return w;
    endfunction

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("lagrange_basis_evaluator verification failed");
            $finish;
        end
    end

    // result side: random stall bursts, sampled at the rising edge
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_basis_word got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.basis_value = out_ch.basis_value;
            got.bad_select  = out_ch.bad_select;
            board.check(got);
        end
    end

    task automatic send_word(input logic [IDX_W-1:0] idx, input logic [ORD_W-1:0] ord,
                             input logic signed [POS_W-1:0] pos);
        t_basis_word want;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        in_ch.valid            = 1'b1;
        in_ch.basis_index      = idx;
        in_ch.derivative_order = ord;
        in_ch.position         = pos;
        want = predict_basis(degree_reg, idx, ord, pos);
        do @(posedge i_clk); while (!in_ch.ready);
        board.note(want);
    endtask

    task automatic write_degree(input logic [DEG_W-1:0] v);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        degree_reg = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_word();
        int                      p;
        logic [IDX_W-1:0]        idx;
        logic [ORD_W-1:0]        ord;
        logic signed [POS_W-1:0] pos;
        p = (degree_reg < 1) ? 1 : (degree_reg > DEG_LIMIT) ? DEG_LIMIT : degree_reg;
        idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(1, p + 1));
        ord = ($urandom_range(0, 9) == 0) ? ORD_BAD : ORD_W'($urandom_range(0, 2));
        if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom);
        else pos = POS_W'($urandom_range(0, 2 * X_OFFSET)) - POS_W'(X_OFFSET);
        send_word(idx, ord, pos);
    endtask

    logic [DEG_W-1:0] degree_plan[8] = '{3'd6, 3'd1, 3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd4};
    logic signed [POS_W-1:0] edge_pos[5] = '{-16'sd16384, 16'sd16384, 16'sd0,
                                             16'sh8000, 16'sh7FFF};

    initial begin
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_data             = '0;
        in_ch.valid            = 1'b0;
        in_ch.basis_index      = '0;
        in_ch.derivative_order = ORD_VALUE;
        in_ch.position         = '0;
        out_ch.ready           = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset degree, then finest grid with edge points and bad selects
        send_word(3'd2, ORD_FIRST, 16'sd0);
        send_word(3'd3, ORD_VALUE, 16'sd0);
        write_degree(3'd6);
        for (int o = 0; o < 4; o++)
            send_word(3'd1, ORD_W'(o), edge_pos[o]);
        send_word(3'd0, ORD_VALUE, 16'sd100);
        send_word(3'd7, ORD_SECOND, 16'sh8000);
        for (int i = 0; i < 5; i++)
            send_word(3'd4, ORD_SECOND, edge_pos[i]);
        for (int i = 0; i < 5; i++)
            send_word(3'd7, ORD_FIRST, edge_pos[i]);
        send_word(3'd5, ORD_VALUE, 16'sh7FFF);

        for (int ph = 0; ph < 8; ph++) begin
            write_degree(degree_plan[ph]);
            if (ph == 7) quiet = 1;
            repeat (100) random_word();
        end

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && board.pending.size() == 0) begin
            $display("lagrange_basis_evaluator verification clean");
        end else begin
            $display("lagrange_basis_evaluator verification failed");
        end
        $finish;
    end
endmodule
